[hdl/nla_pkg.sv]
package nla_pkg;

	// Defaults and fixed field widths
	localparam int MAX_LANDMARKS_DEF = 64;
	localparam int COUNT_W           = 7;
	localparam int SLOT_W            = 6;
	localparam int ID_W              = 16;
	localparam int COORD_W           = 24;
	localparam int DIFF_W            = COORD_W + 1;
	localparam int SQ_W              = 2 * COORD_W + 1;
	localparam int DIST_W            = SQ_W + 1;
	localparam int PADDR_W           = 3;
	localparam int PDATA_W           = 32;

	// Operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Register index, taken from paddr[2]
	localparam logic REG_LANDMARK_COUNT = 1'b0;

	typedef struct packed {
		logic                        operation;
		logic [SLOT_W-1:0]           slot;
		logic [ID_W-1:0]             landmark_id;
		logic signed [COORD_W-1:0]   pos_x;
		logic signed [COORD_W-1:0]   pos_y;
	} nla_in_t;

	typedef struct packed {
		logic                        valid_res;
		logic [ID_W-1:0]             nearest_id;
		logic signed [COORD_W-1:0]   nearest_x;
		logic signed [COORD_W-1:0]   nearest_y;
	} nla_out_t;

	// One table entry
	typedef struct packed {
		logic [ID_W-1:0]             id;
		logic signed [COORD_W-1:0]   x;
		logic signed [COORD_W-1:0]   y;
	} nla_entry_t;

	// Candidate entry entering the distance pipeline
	typedef struct packed {
		logic       vld;
		nla_entry_t entry;
	} nla_cand_t;

	// Candidate leaving the distance pipeline
	typedef struct packed {
		logic              vld;
		logic [DIST_W-1:0] sq_dist;
		nla_entry_t        entry;
	} nla_cand_dist_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} nla_state_t;

endpackage

[hdl/nla_ram.sv]
module nla_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/nla_dist.sv]
module nla_dist (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  nla_pkg::nla_cand_t                     cand_in,
	input  logic signed [nla_pkg::COORD_W-1:0]     qx,
	input  logic signed [nla_pkg::COORD_W-1:0]     qy,
	output nla_pkg::nla_cand_dist_t                cand_out,
	output logic                                   busy
);

	logic                                  vld_s1, vld_s2, vld_s3;
	logic signed [nla_pkg::DIFF_W-1:0]     dx_s1, dy_s1;
	logic [nla_pkg::SQ_W-1:0]              sqx_s2, sqy_s2;
	logic [nla_pkg::DIST_W-1:0]            dist_s3;
	nla_pkg::nla_entry_t                   entry_s1, entry_s2, entry_s3;
	logic signed [nla_pkg::DIFF_W-1:0]     dx, dy;
	logic signed [2*nla_pkg::DIFF_W-1:0]   px, py;

	// Stage 1: coordinate differences, sign extended to avoid overflow
	assign dx = {qx[nla_pkg::COORD_W-1], qx}
		- {cand_in.entry.x[nla_pkg::COORD_W-1], cand_in.entry.x};
	assign dy = {qy[nla_pkg::COORD_W-1], qy}
		- {cand_in.entry.y[nla_pkg::COORD_W-1], cand_in.entry.y};

	// Stage 2: squares, never negative and below 2^49
	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;

	// Valid tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cand_in.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		dx_s1    <= dx;
		dy_s1    <= dy;
		entry_s1 <= cand_in.entry;
		sqx_s2   <= px[nla_pkg::SQ_W-1:0];
		sqy_s2   <= py[nla_pkg::SQ_W-1:0];
		entry_s2 <= entry_s1;
		dist_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		entry_s3 <= entry_s2;
	end

	assign cand_out.vld     = vld_s3;
	assign cand_out.sq_dist = dist_s3;
	assign cand_out.entry   = entry_s3;
	assign busy             = vld_s1 | vld_s2 | vld_s3;

endmodule

[hdl/nearest_landmark_association.sv]
// Channel  Direction  Handshake                      Payload
// in       to block   in_valid / in_ready            in_data  (nla_in_t)
// out      from block out_valid / out_ready          out_data (nla_out_t)
// apb      to block   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A load writes its entry into the table at the transfer edge.
// A query with count n (capped at MAX_LANDMARKS) raises out_valid after one table
// read per cycle from the landmark RAM, a three-stage distance pipeline
// (difference, square, sum) and a running minimum; in_ready rises together with
// out_valid. With a count of zero the query goes straight to the result.
// Reset clears control state only; the table holds no value until loaded.
// The result sits in an output register, so loads are taken while it waits;
// a finished query holds in its last state until that register is free.
module nearest_landmark_association #(
	parameter int MAX_LANDMARKS = nla_pkg::MAX_LANDMARKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  nla_pkg::nla_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output nla_pkg::nla_out_t             out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nla_pkg::PADDR_W-1:0]   paddr,
	input  logic [nla_pkg::PDATA_W-1:0]   pwdata,
	output logic [nla_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int AW    = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int CNT_W = ($clog2(MAX_LANDMARKS + 1) > nla_pkg::COUNT_W)
		? $clog2(MAX_LANDMARKS + 1) : nla_pkg::COUNT_W;
	localparam int EW    = $bits(nla_pkg::nla_entry_t);

	nla_pkg::nla_state_t          state_q, state_d;
	logic [nla_pkg::COUNT_W-1:0]  count_q;
	logic [CNT_W-1:0]             n_q, cnt_q, n_sat, max_c;
	logic signed [nla_pkg::COORD_W-1:0] qx_q, qy_q;
	logic                         rd_vld_q;
	logic                         found_q;
	logic [nla_pkg::DIST_W-1:0]   best_d_q;
	nla_pkg::nla_entry_t          best_q;
	logic                         out_valid_q;
	nla_pkg::nla_out_t            out_data_q;

	logic                         in_xfer, is_query, slot_ok, ram_we, issue, res_load;
	logic                         pipe_busy, dist_busy, cfg_wr;
	logic [EW-1:0]                ram_rdata;
	nla_pkg::nla_entry_t          wr_entry;
	nla_pkg::nla_cand_t           cand_in;
	nla_pkg::nla_cand_dist_t      cand_out;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready
		& (paddr[2] == nla_pkg::REG_LANDMARK_COUNT);
	assign prdata = (paddr[2] == nla_pkg::REG_LANDMARK_COUNT)
		? nla_pkg::PDATA_W'(count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr) begin
			count_q <= pwdata[nla_pkg::COUNT_W-1:0];
		end
	end

	// Count saturated to the table depth
	assign max_c = CNT_W'(MAX_LANDMARKS);
	assign n_sat = (CNT_W'(count_q) > max_c) ? max_c : CNT_W'(count_q);

	// Input decode
	assign in_xfer  = in_valid & in_ready;
	assign is_query = in_data.operation == nla_pkg::OP_QUERY;
	assign slot_ok  = CNT_W'(in_data.slot) < max_c;
	assign ram_we   = in_xfer & !is_query & slot_ok;
	assign wr_entry = '{id: in_data.landmark_id, x: in_data.pos_x, y: in_data.pos_y};

	// Landmark table
	nla_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_LANDMARKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_data.slot)),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (cnt_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Distance pipeline
	assign cand_in.vld   = rd_vld_q;
	assign cand_in.entry = ram_rdata;

	nla_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.cand_in  (cand_in),
		.qx       (qx_q),
		.qy       (qy_q),
		.cand_out (cand_out),
		.busy     (dist_busy)
	);

	assign pipe_busy = rd_vld_q | dist_busy;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nla_pkg::ST_IDLE: begin
				if (in_xfer && is_query) begin
					state_d = (n_sat == '0) ? nla_pkg::ST_DONE : nla_pkg::ST_SCAN;
				end
			end
			nla_pkg::ST_SCAN: begin
				if (cnt_q == n_q - CNT_W'(1)) begin
					state_d = nla_pkg::ST_DRAIN;
				end
			end
			nla_pkg::ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = nla_pkg::ST_DONE;
				end
			end
			nla_pkg::ST_DONE: begin
				if (res_load) begin
					state_d = nla_pkg::ST_IDLE;
				end
			end
			default: state_d = nla_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		res_load = 1'b0;
		case (state_q)
			nla_pkg::ST_IDLE:  in_ready = 1'b1;
			nla_pkg::ST_SCAN:  issue    = 1'b1;
			nla_pkg::ST_DRAIN: ;
			nla_pkg::ST_DONE:  res_load = !out_valid_q | out_ready;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nla_pkg::ST_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			rd_vld_q    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= issue;
			if (in_xfer && is_query) begin
				cnt_q   <= '0;
				n_q     <= n_sat;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (cand_out.vld) begin
					found_q <= 1'b1;
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Query point, running minimum and result payload
	always_ff @(posedge clk) begin
		if (in_xfer && is_query) begin
			qx_q <= in_data.pos_x;
			qy_q <= in_data.pos_y;
		end
		// strict compare keeps the earlier entry on a tie
		if (cand_out.vld && (!found_q || cand_out.sq_dist < best_d_q)) begin
			best_d_q <= cand_out.sq_dist;
			best_q   <= cand_out.entry;
		end
		if (res_load) begin
			out_data_q.valid_res  <= found_q;
			out_data_q.nearest_id <= found_q ? best_q.id : '0;
			out_data_q.nearest_x  <= found_q ? best_q.x : '0;
			out_data_q.nearest_y  <= found_q ? best_q.y : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Reads stay inside the searched range
	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> cnt_q < n_q)
		else $error("table read beyond the searched count");

	// No candidate may still be in flight once the result is ready
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nla_pkg::ST_DONE) |-> !pipe_busy)
		else $error("candidate in flight at result time");

	// An empty result only comes from an empty search
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && !found_q) |-> (n_q == '0))
		else $error("no landmark found in a non-empty search");

	// A scan always has something to read
	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nla_pkg::ST_SCAN) |-> (n_q != '0))
		else $error("scan started with zero count");

endmodule
